### design/tbwse_pkg.sv
// Shared types, codes and constants of the timer bank.
package tbwse_pkg;

    localparam int unsigned KIND_W      = 3;
    localparam int unsigned SLOT_W      = 8;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = 5;
    localparam logic [TICK_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_STAMP  = 3'd4,
        KIND_SCAN   = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic rd_issue;
        logic rd_scan;
        logic apply;
        logic scan_clear;
        logic scan_eval;
        logic scan_next;
        logic scan_final;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_scan;
        logic hit;
        logic pend_valid;
        logic stop;
        logic out_free;
    } dp_stat_t;

endpackage

### design/tbwse_in_if.sv
// Command channel of the timer bank.
interface tbwse_in_if import tbwse_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot_index;
    logic                periodic;
    logic [TICK_W-1:0]   period;
    logic [TICK_W-1:0]   time_stamp;

    modport source (output valid, kind, slot_index, periodic, period, time_stamp,
                    input ready);
    modport sink   (input valid, kind, slot_index, periodic, period, time_stamp,
                    output ready);
endinterface

### design/tbwse_out_if.sv
// Result channel of the timer bank.
interface tbwse_out_if import tbwse_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   expired_slot;
    logic [TICK_W-1:0]   tick_now;
    logic                last;

    modport source (output valid, status, expired_slot, tick_now, last,
                    input ready);
    modport sink   (input valid, status, expired_slot, tick_now, last,
                    output ready);
endinterface

### design/tbwse_ctrl.sv
// Sequencing state machine of the timer bank.
module tbwse_ctrl import tbwse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_APPLY   = 6'b000100,
        S_SCAN_RD = 6'b001000,
        S_SCAN_EV = 6'b010000,
        S_SCAN_END = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_scan)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN_RD;
                end
                else
                begin
                    // fetch the interval for a start
                    cmd.rd_issue = 1'b1;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_scan  = 1'b1;
                state_next   = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                // hold while a pending beat cannot be handed over
                if (!(stat.hit && stat.pend_valid && !stat.out_free))
                begin
                    cmd.scan_eval = 1'b1;
                    if (stat.stop)
                    begin
                        state_next = S_SCAN_END;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_END:
            begin
                if (stat.out_free)
                begin
                    cmd.scan_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/tbwse_dp.sv
// Slot storage, tick arithmetic, scan registers and result register.
module tbwse_dp import tbwse_pkg::*;
#(
    parameter int unsigned TIMERS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic                periodic,
    input  logic [TICK_W-1:0]   period,
    input  logic [TICK_W-1:0]   time_stamp,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   expired_slot,
    output logic [TICK_W-1:0]   tick_now,
    output logic                last
);

    localparam int unsigned IDXW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    // latched item
    logic [KIND_W-1:0]  kind_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic               per_reg;
    logic [TICK_W-1:0]  period_reg;
    logic [TICK_W-1:0]  stamp_reg;

    // slot flags
    logic [TIMERS-1:0]  used_reg;
    logic [TIMERS-1:0]  active_reg;
    logic [TIMERS-1:0]  periodic_reg;

    // slot memories
    logic [TICK_W-1:0]  interval_mem [TIMERS];
    logic [TICK_W-1:0]  deadline_mem [TIMERS];
    logic [TICK_W-1:0]  ivl_rd_reg;
    logic [TICK_W-1:0]  dl_rd_reg;

    // time base
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  prev_reg;
    logic               first_reg;

    // scan
    logic [IDXW-1:0]    scan_i_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               pend_valid_reg;
    logic [IDXW-1:0]    pend_idx_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TICK_W-1:0]   out_tick_reg;
    logic                out_last_reg;

    kind_t              kind_e;
    logic               in_range;
    logic [IDXW-1:0]    slot;
    logic [IDXW-1:0]    rd_addr;
    status_t            s_status;
    logic               create_set;
    logic               start_set;
    logic               stop_clr;
    logic               del_clr;
    logic               stamp_upd;
    logic [TICK_W-1:0]  tick_adv;
    logic [TICK_W-1:0]  tick_out;
    logic               hit;
    logic               scan_hit;
    logic               dl_we;
    logic [IDXW-1:0]    dl_waddr;
    logic [TICK_W-1:0]  dl_wdata;
    logic               out_free;
    logic               push;
    status_t            p_status;
    logic [SLOT_W-1:0]  p_slot;
    logic               p_last;

    assign kind_e   = kind_t'(kind_reg);
    assign in_range = ({1'b0, idx_reg} < 9'(TIMERS));
    assign slot     = idx_reg[IDXW-1:0];
    assign rd_addr  = cmd.rd_scan ? scan_i_reg : slot;

    always_comb
    begin
        s_status   = ST_OK;
        create_set = 1'b0;
        start_set  = 1'b0;
        stop_clr   = 1'b0;
        del_clr    = 1'b0;
        stamp_upd  = 1'b0;
        unique case (kind_e)
            KIND_CREATE:
            begin
                if (in_range) create_set = cmd.apply;
                else          s_status   = ST_INVALID;
            end
            KIND_START:
            begin
                if (in_range && used_reg[slot]) start_set = cmd.apply;
                else                            s_status  = ST_INVALID;
            end
            KIND_STOP:
            begin
                if (in_range && used_reg[slot]) stop_clr = cmd.apply;
                else                            s_status = ST_INVALID;
            end
            KIND_DELETE:
            begin
                if (in_range) del_clr  = cmd.apply;
                else          s_status = ST_INVALID;
            end
            KIND_STAMP:
            begin
                stamp_upd = cmd.apply;
            end
            default:
            begin
                s_status = ST_OK;
            end
        endcase
    end

    // first stamp only sets the base
    assign tick_adv = first_reg ? tick_reg : tick_reg + (stamp_reg - prev_reg);
    assign tick_out = (kind_e == KIND_STAMP) ? tick_adv : tick_reg;

    // wrap-safe compare against the deadline of the visited slot
    assign hit = used_reg[scan_i_reg] && active_reg[scan_i_reg]
                 && ((tick_reg - dl_rd_reg) <= HALF_RANGE);
    assign scan_hit = cmd.scan_eval && hit;

    assign dl_we    = start_set || (scan_hit && periodic_reg[scan_i_reg]);
    assign dl_waddr = cmd.scan_eval ? scan_i_reg : slot;
    assign dl_wdata = cmd.scan_eval ? dl_rd_reg + ivl_rd_reg : tick_reg + ivl_rd_reg;

    assign out_free = !out_valid_reg || rsp_ready;
    assign push     = cmd.apply || (scan_hit && pend_valid_reg) || cmd.scan_final;

    assign stat.is_scan    = (kind_e == KIND_SCAN);
    assign stat.hit        = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.stop       = (scan_i_reg == IDXW'(TIMERS - 1))
                             || (hit && (cnt_reg == CNT_W'(MAX_RESULTS - 1)));
    assign stat.out_free   = out_free;

    always_comb
    begin
        if (cmd.apply)
        begin
            p_status = s_status;
            p_slot   = '0;
            p_last   = 1'b1;
        end
        else if (cmd.scan_final && !pend_valid_reg)
        begin
            p_status = ST_NONE;
            p_slot   = '0;
            p_last   = 1'b1;
        end
        else
        begin
            p_status = ST_EXPIRED;
            p_slot   = SLOT_W'(pend_idx_reg);
            p_last   = cmd.scan_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg   <= kind;
            idx_reg    <= slot_index;
            per_reg    <= periodic;
            period_reg <= period;
            stamp_reg  <= time_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (create_set)
        begin
            interval_mem[slot] <= period_reg;
        end
        if (dl_we)
        begin
            deadline_mem[dl_waddr] <= dl_wdata;
        end
        if (cmd.rd_issue)
        begin
            ivl_rd_reg <= interval_mem[rd_addr];
            dl_rd_reg  <= deadline_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            active_reg   <= '0;
            periodic_reg <= '0;
        end
        else
        begin
            if (create_set)
            begin
                used_reg[slot]     <= 1'b1;
                active_reg[slot]   <= 1'b0;
                periodic_reg[slot] <= per_reg;
            end
            if (start_set)
            begin
                active_reg[slot] <= 1'b1;
            end
            if (stop_clr)
            begin
                active_reg[slot] <= 1'b0;
            end
            if (del_clr)
            begin
                used_reg[slot]     <= 1'b0;
                active_reg[slot]   <= 1'b0;
                periodic_reg[slot] <= 1'b0;
            end
            // one-shot slots stop on expiry
            if (scan_hit && !periodic_reg[scan_i_reg])
            begin
                active_reg[scan_i_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            prev_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (stamp_upd)
        begin
            tick_reg  <= tick_adv;
            prev_reg  <= stamp_reg;
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_i_reg     <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else if (cmd.scan_clear)
        begin
            scan_i_reg     <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_hit)
            begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= scan_i_reg;
                cnt_reg        <= cnt_reg + 1'b1;
            end
            if (cmd.scan_next)
            begin
                scan_i_reg <= scan_i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_status_reg <= p_status;
            out_slot_reg   <= p_slot;
            out_tick_reg   <= tick_out;
            out_last_reg   <= p_last;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign expired_slot = out_slot_reg;
    assign tick_now     = out_tick_reg;
    assign last         = out_last_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over an unread beat");

    a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg == (cnt_reg != '0))
        else $error("pending result and hit count disagree");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("scan reported more than the result cap");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_NONE) |-> out_last_reg && (out_slot_reg == '0))
        else $error("empty-scan beat is not final or carries a slot");

endmodule

### design/timer_bank_with_wrap_safe_expiry.sv
// Top level of the timer bank: controller, datapath and channel wiring.
// Create, start, stop, delete, timestamp and unknown kinds: the item is latched, slot memories are
// read, and the single result beat is registered once the result register is free; the next command
// is taken the cycle after. Expiry scan: each slot visited takes a registered memory read, then a
// compare and reload; the pass stalls while the result register is held.
// Scan pace is set by the single read port of the interval and deadline memories. Reset clears
// slot flags, tick, stamp base, first-stamp flag, scan state and result valid; slot memories need no clear.
module timer_bank_with_wrap_safe_expiry import tbwse_pkg::*;
#(
    parameter int unsigned TIMERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    tbwse_in_if.sink    cmd,
    tbwse_out_if.source rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     in_ready;

    // accept one command beat at a time; the controller owns ready
    assign cmd.ready = in_ready;

    tbwse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // slot state, tick arithmetic and the result register
    tbwse_dp #(
        .TIMERS (TIMERS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .kind         (cmd.kind),
        .slot_index   (cmd.slot_index),
        .periodic     (cmd.periodic),
        .period       (cmd.period),
        .time_stamp   (cmd.time_stamp),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .status       (rsp.status),
        .expired_slot (rsp.expired_slot),
        .tick_now     (rsp.tick_now),
        .last         (rsp.last)
    );

endmodule

### bench/tb_top.sv
// Testbench of the timer bank: directed and random commands checked against a shadow model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbwse_pkg::*;

    // Size of the bank under test and the two kinds the block must treat as no-ops.
    localparam int unsigned          NUM_SLOTS        = 16;
    localparam logic [KIND_W-1:0]    KIND_SPARE_A     = 3'd6;
    localparam logic [KIND_W-1:0]    KIND_SPARE_B     = 3'd7;
    // Long receiver hold-off, and the quiet time after the last report beat.
    // The quiet time is sized to outlast a full scan.
    localparam int unsigned          LONG_HOLD_CYCLES = 150;
    localparam int unsigned          SETTLE_CYCLES    = 2 * NUM_SLOTS + 8;
    // Worst case is far below this: 162 commands, each with up to 16 report beats and stalls.
    localparam int unsigned          RUN_LIMIT_NS     = 1_000_000;

    // One command beat, with every field at the width of the channel.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              periodic;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] stamp;
    } timer_cmd_t;

    // One report beat as the block should produce it.
    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] tick;
        logic              last;
    } timer_report_t;

    logic clk = 1'b0;
    logic rst_n;

    tbwse_in_if  cmd_ch ();
    tbwse_out_if rsp_ch ();

    timer_bank_with_wrap_safe_expiry #(
        .TIMERS (NUM_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // Shadow copy of the bank, updated at the edge where each command beat is taken.
    logic              shadow_used     [NUM_SLOTS];
    logic              shadow_active   [NUM_SLOTS];
    logic              shadow_periodic [NUM_SLOTS];
    logic [TICK_W-1:0] shadow_interval [NUM_SLOTS];
    logic [TICK_W-1:0] shadow_deadline [NUM_SLOTS];
    logic [TICK_W-1:0] shadow_tick;
    logic [TICK_W-1:0] shadow_prev_stamp;
    logic              shadow_need_base;

    // Report beats still owed by the block, oldest first.
    timer_report_t report_queue [$];

    int unsigned       mismatch_count;
    logic [TICK_W-1:0] stamp_cursor;
    // Idling controls shared by the sender, the receiver and the tests.
    bit                cmd_gaps_on;
    bit                rsp_stalls_on;
    bit                rsp_hold_req;

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_used[i]     = 1'b0;
            shadow_active[i]   = 1'b0;
            shadow_periodic[i] = 1'b0;
            shadow_interval[i] = '0;
            shadow_deadline[i] = '0;
        end
        shadow_tick       = '0;
        shadow_prev_stamp = '0;
        shadow_need_base  = 1'b1;
    end

    // Apply one accepted command to the shadow bank and queue the beats it owes.
    task automatic shadow_step(input timer_cmd_t c);
        timer_report_t     rep;
        timer_report_t     held;
        logic              have_held;
        logic              in_range;
        int unsigned       idx;
        int unsigned       hits;
        logic [TICK_W-1:0] age;
        idx        = 32'(c.slot);
        in_range   = (idx < NUM_SLOTS);
        rep.status = ST_OK;
        rep.slot   = '0;
        rep.last   = 1'b1;
        if (c.kind == KIND_SCAN)
        begin
            hits      = 0;
            have_held = 1'b0;
            // Walk the slots in ascending order; a deadline counts as reached when the
            // wrapped age lands in the lower half of the 32-bit range.
            for (int i = 0; i < NUM_SLOTS && hits < MAX_RESULTS; i++)
            begin
                age = shadow_tick - shadow_deadline[i];
                if (shadow_used[i] && shadow_active[i] && age <= HALF_RANGE)
                begin
                    if (shadow_periodic[i])
                        shadow_deadline[i] = shadow_deadline[i] + shadow_interval[i];
                    else
                        shadow_active[i] = 1'b0;
                    if (have_held)
                        report_queue.push_back(held);
                    held.status = ST_EXPIRED;
                    held.slot   = SLOT_W'(i);
                    held.tick   = shadow_tick;
                    held.last   = 1'b0;
                    have_held   = 1'b1;
                    hits++;
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                report_queue.push_back(held);
            end
            else
            begin
                rep.status = ST_NONE;
                rep.tick   = shadow_tick;
                report_queue.push_back(rep);
            end
        end
        else
        begin
            case (c.kind)
                KIND_CREATE:
                begin
                    if (!in_range)
                        rep.status = ST_INVALID;
                    else
                    begin
                        // the old deadline stays; start, not create, sets it
                        shadow_used[idx]     = 1'b1;
                        shadow_active[idx]   = 1'b0;
                        shadow_periodic[idx] = c.periodic;
                        shadow_interval[idx] = c.period;
                    end
                end
                KIND_START:
                begin
                    if (!in_range || !shadow_used[idx])
                        rep.status = ST_INVALID;
                    else
                    begin
                        shadow_deadline[idx] = shadow_tick + shadow_interval[idx];
                        shadow_active[idx]   = 1'b1;
                    end
                end
                KIND_STOP:
                begin
                    if (!in_range || !shadow_used[idx])
                        rep.status = ST_INVALID;
                    else
                        shadow_active[idx] = 1'b0;
                end
                KIND_DELETE:
                begin
                    if (!in_range)
                        rep.status = ST_INVALID;
                    else
                    begin
                        shadow_used[idx]     = 1'b0;
                        shadow_active[idx]   = 1'b0;
                        shadow_periodic[idx] = 1'b0;
                        shadow_interval[idx] = '0;
                        shadow_deadline[idx] = '0;
                    end
                end
                KIND_STAMP:
                begin
                    // the first stamp after reset only sets the base
                    if (shadow_need_base)
                        shadow_need_base = 1'b0;
                    else
                        shadow_tick = shadow_tick + (c.stamp - shadow_prev_stamp);
                    shadow_prev_stamp = c.stamp;
                end
                default:
                begin
                    // spare kinds answer ok and touch nothing
                end
            endcase
            rep.tick = shadow_tick;
            report_queue.push_back(rep);
        end
    endtask

    // Drive one command beat at the falling edge, hold it until taken, then predict.
    task automatic send_command(input timer_cmd_t c);
        int unsigned gap;
        @(negedge clk);
        if (cmd_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.kind       = c.kind;
        cmd_ch.slot_index = c.slot;
        cmd_ch.periodic   = c.periodic;
        cmd_ch.period     = c.period;
        cmd_ch.time_stamp = c.stamp;
        cmd_ch.valid      = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        shadow_step(c);
    endtask

    function automatic timer_cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic              periodic,
                                            input logic [TICK_W-1:0] period,
                                            input logic [TICK_W-1:0] stamp);
        timer_cmd_t c;
        c.kind     = kind;
        c.slot     = slot;
        c.periodic = periodic;
        c.period   = period;
        c.stamp    = stamp;
        return c;
    endfunction

    // Build a random command. Well-formed ones address real slots, use mostly short periods
    // and mostly move the stamp forward a little, so timers actually come due; the rest is
    // noise over every field, spare kinds and far slot indexes included.
    function automatic timer_cmd_t random_command(input bit well_formed);
        timer_cmd_t  c;
        int unsigned pick;
        c.kind     = KIND_W'($urandom_range(0, 7));
        c.slot     = SLOT_W'($urandom_range(0, 255));
        c.periodic = 1'($urandom_range(0, 1));
        c.period   = $urandom();
        c.stamp    = $urandom();
        if (well_formed)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
                c.kind = KIND_CREATE;
            else if (pick < 34)
                c.kind = KIND_START;
            else if (pick < 42)
                c.kind = KIND_STOP;
            else if (pick < 46)
                c.kind = KIND_DELETE;
            else if (pick < 70)
                c.kind = KIND_STAMP;
            else
                c.kind = KIND_SCAN;
            c.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            if ($urandom_range(0, 9) != 0)
                c.period = $urandom_range(0, 300);
            if ($urandom_range(0, 19) != 0)
                stamp_cursor = stamp_cursor + $urandom_range(0, 200);
            else
                stamp_cursor = $urandom();
            c.stamp = stamp_cursor;
        end
        return c;
    endfunction

    // Drop valid, wait for every owed beat, then let the block go quiet.
    task automatic drain_bank();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (report_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Far slot indexes, start and stop of slots never created, and the spare kinds.
    task automatic test_command_errors();
        send_command(make_cmd(KIND_CREATE, 8'd16, 1'b1, 32'hFFFF_FFFF, 32'h0));
        send_command(make_cmd(KIND_START, 8'd255, 1'b0, 32'h0, 32'hFFFF_FFFF));
        send_command(make_cmd(KIND_STOP, 8'd5, 1'b1, 32'h0, 32'h0));
        send_command(make_cmd(KIND_START, 8'd5, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_DELETE, 8'd200, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_SPARE_A, 8'd3, 1'b1, 32'h1234_5678, 32'hA5A5_A5A5));
        send_command(make_cmd(KIND_SPARE_B, 8'd255, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain_bank();
    endtask

    // Empty scan, first stamp as base, stamp wrap, zero and maximum periods, the exact
    // half-range boundary, periodic reload and one-shot stop.
    task automatic test_stamps_and_expiry();
        send_command(make_cmd(KIND_SCAN, 8'd0, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_STAMP, 8'd0, 1'b0, 32'h0, 32'hFFFF_FFF0));
        send_command(make_cmd(KIND_CREATE, 8'd0, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_START, 8'd0, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_CREATE, 8'd1, 1'b1, 32'd20, 32'h0));
        send_command(make_cmd(KIND_START, 8'd1, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_CREATE, 8'd2, 1'b0, 32'hFFFF_FFFF, 32'h0));
        send_command(make_cmd(KIND_CREATE, 8'd15, 1'b1, 32'h8000_0000, 32'h0));
        // stamp wraps past zero: the tick moves by 0x20
        send_command(make_cmd(KIND_STAMP, 8'd0, 1'b0, 32'h0, 32'h0000_0010));
        send_command(make_cmd(KIND_START, 8'd2, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_START, 8'd15, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_SCAN, 8'd0, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_SCAN, 8'd0, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_DELETE, 8'd1, 1'b0, 32'h0, 32'h0));
        send_command(make_cmd(KIND_STOP, 8'd15, 1'b0, 32'h0, 32'h0));
        drain_bank();
        stamp_cursor = 32'h0000_0010;
    endtask

    // Mostly well-formed traffic, idling switched on and off in stretches.
    task automatic test_random_mix(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 20 == 0)
            begin
                cmd_gaps_on   = ($urandom_range(0, 3) != 0);
                rsp_stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_command(random_command($urandom_range(0, 9) != 0));
        end
        drain_bank();
        cmd_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
    endtask

    // Hold the receiver off for a long stretch while commands keep coming, so the
    // block fills up and must stall its command channel.
    task automatic test_output_backpressure();
        timer_cmd_t c;
        cmd_gaps_on  = 1'b0;
        rsp_hold_req = 1'b1;
        for (int unsigned n = 0; n < 10; n++)
        begin
            c = random_command(1'b1);
            if (n % 2 == 0)
                c.kind = KIND_SCAN;
            send_command(c);
        end
        drain_bank();
        cmd_gaps_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_random_steady(input int unsigned count);
        cmd_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        for (int unsigned n = 0; n < count; n++)
            send_command(random_command($urandom_range(0, 9) != 0));
        drain_bank();
    endtask

    // Receiver: random stall bursts, plus one long hold-off counted here.
    initial
    begin : rsp_ready_driver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left   = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_req)
            begin
                hold_left    = LONG_HOLD_CYCLES;
                rsp_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if (rsp_stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(1, 9) - 1;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                               input logic [TICK_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each report beat taken at the rising edge with the oldest owed one.
    always @(posedge clk)
    begin : report_checker
        timer_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (report_queue.size() == 0)
            begin
                $error("report beat with nothing owed: status %0d slot %0d tick 0x%0h",
                       rsp_ch.status, rsp_ch.expired_slot, rsp_ch.tick_now);
                mismatch_count++;
            end
            else
            begin
                want = report_queue.pop_front();
                check_field("status", TICK_W'(want.status), TICK_W'(rsp_ch.status));
                check_field("expired_slot", TICK_W'(want.slot), TICK_W'(rsp_ch.expired_slot));
                check_field("tick_now", want.tick, rsp_ch.tick_now);
                check_field("last", TICK_W'(want.last), TICK_W'(rsp_ch.last));
            end
        end
    end

    // Hard limit on the whole run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = '0;
        cmd_ch.slot_index = '0;
        cmd_ch.periodic   = 1'b0;
        cmd_ch.period     = '0;
        cmd_ch.time_stamp = '0;
        mismatch_count    = 0;
        stamp_cursor      = '0;
        cmd_gaps_on       = 1'b1;
        rsp_stalls_on     = 1'b1;
        rsp_hold_req      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_command_errors();
        test_stamps_and_expiry();
        test_random_mix(70);
        test_output_backpressure();
        test_random_steady(60);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
